/* rtl/dmf_pkg.sv */
// ============================================================================
// dmf_pkg: shared types and constants of the duplicate message filter
// Holds the ring size, field widths, action codes, the probe and write
// structs that travel along the cell chain, and the control state type.
// ============================================================================
package dmf_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int ID_W    = 64;
  localparam int NONCE_W = 32;
  localparam int TYPE_W  = 8;
  localparam int LEN_W   = 8;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // A search key walking down the chain together with what it found so far.
  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [NONCE_W-1:0] nonce;
    logic               hit;
    logic [TYPE_W-1:0]  kind;
    logic [LEN_W-1:0]   len;
  } probe_t;

  // Write command broadcast to every cell; only the addressed one takes it.
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    id;
    logic [NONCE_W-1:0] nonce;
    logic [TYPE_W-1:0]  kind;
    logic [LEN_W-1:0]   len;
  } wr_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } ctrl_state_t;

endpackage

/* rtl/dmf_ifs.sv */
// ============================================================================
// dmf_ifs: channel interfaces of the duplicate message filter
// One interface for the request channel and one for the result channel,
// each with a source and a sink modport and a valid/ready handshake.
// ============================================================================
interface dmf_in_if
  import dmf_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               action;
  logic [ID_W-1:0]    msg_id;
  logic [NONCE_W-1:0] nonce;
  logic [TYPE_W-1:0]  msg_type;
  logic [LEN_W-1:0]   msg_length;

  modport source (output valid, action, msg_id, nonce, msg_type, msg_length,
                  input ready);
  modport sink   (input valid, action, msg_id, nonce, msg_type, msg_length,
                  output ready);
endinterface

interface dmf_out_if
  import dmf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              hit;
  logic              stored;
  logic [TYPE_W-1:0] hit_type;
  logic [LEN_W-1:0]  hit_length;

  modport source (output valid, hit, stored, hit_type, hit_length, input ready);
  modport sink   (input valid, hit, stored, hit_type, hit_length, output ready);
endinterface

/* rtl/dmf_cell.sv */
// ============================================================================
// dmf_cell: one entry of the duplicate filter ring
// Stores one entry and compares the probe passing through it, registering the
// probe before handing it on to the next cell.
// ============================================================================
module dmf_cell
  import dmf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] slot_idx,
  input  wr_cmd_t           wr,
  input  probe_t            probe_in,
  output probe_t            probe_out
);

  logic               valid_r;
  logic [ID_W-1:0]    id_r;
  logic [NONCE_W-1:0] nonce_r;
  logic [TYPE_W-1:0]  kind_r;
  logic [LEN_W-1:0]   len_r;
  probe_t             probe_r;
  probe_t             probe_nxt;
  logic               match;

  assign match = valid_r && (id_r == probe_in.id) && (nonce_r == probe_in.nonce);

  always_comb begin
    probe_nxt = probe_in;
    if (probe_in.valid && !probe_in.hit && match) begin
      probe_nxt.hit  = 1'b1;
      probe_nxt.kind = kind_r;
      probe_nxt.len  = len_r;
    end
  end

  // Only the valid bits are reset; the entry and probe payload are don't-care
  // until their valid bit is set.
  always_ff @(posedge clk) begin
    probe_r.id    <= probe_nxt.id;
    probe_r.nonce <= probe_nxt.nonce;
    probe_r.hit   <= probe_nxt.hit;
    probe_r.kind  <= probe_nxt.kind;
    probe_r.len   <= probe_nxt.len;
    if (wr.en && (wr.slot == slot_idx)) begin
      id_r    <= wr.id;
      nonce_r <= wr.nonce;
      kind_r  <= wr.kind;
      len_r   <= wr.len;
    end
    if (!rst_n) begin
      valid_r       <= 1'b0;
      probe_r.valid <= 1'b0;
    end else begin
      probe_r.valid <= probe_nxt.valid;
      if (wr.en && (wr.slot == slot_idx)) begin
        valid_r <= 1'b1;
      end
    end
  end

  assign probe_out = probe_r;

endmodule

/* rtl/dmf_ctrl.sv */
// ============================================================================
// dmf_ctrl: sequencer of the duplicate message filter
// Launches one probe into the cell chain, waits for it at the tail, issues
// the ring write on an insert miss and hands the result to the output register.
// ============================================================================
module dmf_ctrl
  import dmf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  dmf_in_if.sink        in_ch,
  dmf_out_if.source     out_ch,
  input  probe_t        tail,
  output probe_t        head,
  output wr_cmd_t       wr
);

  ctrl_state_t       state_r, state_nxt;
  logic              act_r;
  logic [TYPE_W-1:0] kind_r;
  logic [LEN_W-1:0]  len_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic              res_hit_r, res_hit_nxt;
  logic              res_stored_r, res_stored_nxt;
  logic [TYPE_W-1:0] res_type_r, res_type_nxt;
  logic [LEN_W-1:0]  res_len_r, res_len_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_stored_r;
  logic [TYPE_W-1:0] out_type_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_load;
  logic              accept;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    head.valid = accept;
    head.id    = in_ch.msg_id;
    head.nonce = in_ch.nonce;
    head.hit   = 1'b0;
    head.kind  = '0;
    head.len   = '0;
  end

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    res_hit_nxt    = res_hit_r;
    res_stored_nxt = res_stored_r;
    res_type_nxt   = res_type_r;
    res_len_nxt    = res_len_r;
    out_load       = 1'b0;
    wr.en          = 1'b0;
    wr.slot        = slot_r;
    wr.id          = tail.id;
    wr.nonce       = tail.nonce;
    wr.kind        = kind_r;
    wr.len         = len_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.valid) begin
          res_hit_nxt    = tail.hit;
          res_stored_nxt = !tail.hit && (act_r == ACT_INSERT);
          res_type_nxt   = tail.kind;
          res_len_nxt    = tail.len;
          wr.en          = !tail.hit && (act_r == ACT_INSERT);
          if (wr.en) begin
            slot_nxt = (slot_r == SLOT_W'(SLOTS - 1)) ? '0 : slot_r + 1'b1;
          end
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_ch.action;
      kind_r <= in_ch.msg_type;
      len_r  <= in_ch.msg_length;
    end
    res_hit_r    <= res_hit_nxt;
    res_stored_r <= res_stored_nxt;
    res_type_r   <= res_type_nxt;
    res_len_r    <= res_len_nxt;
    if (out_load) begin
      out_hit_r    <= res_hit_r;
      out_stored_r <= res_stored_r;
      out_type_r   <= res_type_r;
      out_len_r    <= res_len_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.stored     = out_stored_r;
  assign out_ch.hit_type   = out_type_r;
  assign out_ch.hit_length = out_len_r;

endmodule

/* rtl/duplicate_message_filter_core.sv */
// ============================================================================
// duplicate_message_filter_core: flooding duplicate filter with FIFO replacement
// Keeps a ring of SLOTS message keys in a chain of cells and answers insert
// and lookup requests by walking the key down the chain.
// ============================================================================
//
//  Channel | Direction | Handshake     | Payload
//  --------+-----------+---------------+------------------------------------------
//  in_ch   | input     | valid / ready | action, msg_id, nonce, msg_type, msg_length
//  out_ch  | output    | valid / ready | hit, stored, hit_type, hit_length
//
// An item's key visits the cells of the chain one after another, then the result
// is latched once and moved into the output register. A new item is accepted only
// after the result of the last one is in the output register, so only one item is
// searched at a time.
// Reset clears every entry's valid bit and the write slot;
// no clearing pass is needed.
// A stalled result sits in the output register while the next item is already
// accepted and searched; that item then waits in the sequencer until the
// output register frees up.
module duplicate_message_filter_core
  import dmf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dmf_in_if.sink    in_ch,
  dmf_out_if.source out_ch
);

  // probe[0] enters the first cell; probe[i+1] leaves cell i.
  probe_t        probe [SLOTS+1];
  wr_cmd_t       wr;
  logic [SLOTS-1:0] probe_busy;

  dmf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .tail   (probe[SLOTS]),
    .head   (probe[0]),
    .wr     (wr)
  );

  // The ring itself: each cell holds one entry and forwards the key and the
  // match result so far. The write command reaches all cells at once and the
  // cell whose index equals the write slot takes it.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    dmf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .slot_idx  (SLOT_W'(i)),
      .wr        (wr),
      .probe_in  (probe[i]),
      .probe_out (probe[i+1])
    );
    assign probe_busy[i] = probe[i+1].valid;
  end

  // Only one item is ever searched at a time.
  a_single_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(probe_busy))
    else $error("more than one key in flight in the cell chain");

  // An accepted item enters the first cell at the next edge.
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> probe[1].valid)
    else $error("accepted item did not enter the cell chain");

  // The ring is written only when a key leaves the chain without a match.
  a_write_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (probe[SLOTS].valid && !probe[SLOTS].hit))
    else $error("ring write without a completed missed search");

  // No new item is taken while a key is still in the chain.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (probe_busy != '0) |-> !in_ch.ready)
    else $error("input ready while a search is running");

endmodule

/* verif/dmf_filter_checker.sv */
// ============================================================================
// dmf_filter_checker: result predictor and comparator for the duplicate filter
// Mirrors the ring of message keys, works out the answer for every request
// taken on the input channel and compares it with the next result.
// ============================================================================
module dmf_filter_checker
  import dmf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dmf_in_if    in_mon,
  dmf_out_if   out_mon,
  output int   fail_count,
  output int   pending_results,
  output int   hit_count,
  output int   store_count,
  output int   lookup_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic              hit;
    logic              stored;
    logic [TYPE_W-1:0] kind;
    logic [LEN_W-1:0]  len;
  } filter_answer_t;

  // Shadow copy of the key ring.
  logic               ring_valid [SLOTS];
  logic [ID_W-1:0]    ring_id    [SLOTS];
  logic [NONCE_W-1:0] ring_nonce [SLOTS];
  logic [TYPE_W-1:0]  ring_kind  [SLOTS];
  logic [LEN_W-1:0]   ring_len   [SLOTS];
  logic [SLOT_W-1:0]  write_ptr;

  filter_answer_t answers_due[$];
  int             result_index;

  // Searches the ring for the key and, for a new key on an insert, writes it
  // over the oldest entry.
  function automatic filter_answer_t filter_step(input logic act,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [NONCE_W-1:0] nonce,
                                                 input logic [TYPE_W-1:0] kind,
                                                 input logic [LEN_W-1:0] len);
    filter_answer_t ans;
    int             found;
    ans   = '0;
    found = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (found < 0 && ring_valid[s] && ring_id[s] == id && ring_nonce[s] == nonce) begin
        found = s;
      end
    end
    if (found >= 0) begin
      ans.hit  = 1'b1;
      ans.kind = ring_kind[found];
      ans.len  = ring_len[found];
    end else if (act == ACT_INSERT) begin
      ring_valid[write_ptr] = 1'b1;
      ring_id[write_ptr]    = id;
      ring_nonce[write_ptr] = nonce;
      ring_kind[write_ptr]  = kind;
      ring_len[write_ptr]   = len;
      write_ptr  = (write_ptr == SLOT_W'(SLOTS - 1)) ? '0 : write_ptr + 1'b1;
      ans.stored = 1'b1;
    end
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("[%0t] result %0d: %s is %0d, expected %0d", $realtime, result_index,
               what, got, want);
    end
  endtask

  always @(posedge clk) begin
    filter_answer_t want;
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) ring_valid[s] = 1'b0;
      write_ptr    = '0;
      answers_due.delete();
      result_index = 0;
      fail_count   = 0;
      hit_count    = 0;
      store_count  = 0;
      lookup_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        want = filter_step(in_mon.action, in_mon.msg_id, in_mon.nonce,
                           in_mon.msg_type, in_mon.msg_length);
        answers_due.push_back(want);
        if (in_mon.action == ACT_LOOKUP) lookup_count++;
        if (want.hit) hit_count++;
        if (want.stored) store_count++;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected result, queue depth", 1, 0);
        end else begin
          want = answers_due.pop_front();
          if (out_mon.hit !== want.hit) report_mismatch("hit", out_mon.hit, want.hit);
          if (out_mon.stored !== want.stored) begin
            report_mismatch("stored", out_mon.stored, want.stored);
          end
          if (out_mon.hit_type !== want.kind) begin
            report_mismatch("hit_type", out_mon.hit_type, want.kind);
          end
          if (out_mon.hit_length !== want.len) begin
            report_mismatch("hit_length", out_mon.hit_length, want.len);
          end
        end
        result_index++;
      end
    end
    pending_results = answers_due.size();
  end

endmodule

/* verif/tb_top.sv */
// ============================================================================
// tb_top: testbench top of the duplicate message filter
// Drives insert and lookup requests with random gaps, stalls the result
// channel at random, and reports the verdict from the checker's error count.
// ============================================================================
module tb_top
  import dmf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // ITEM_CYCLES is the time an item occupies the block. The watchdog limit
  // covers one item plus the longest sender gap and receiver stall many times.
  localparam int ITEM_CYCLES  = SLOTS + 2;
  localparam int IDLE_LIMIT   = 10 * (ITEM_CYCLES + 20);
  localparam int TAIL_CYCLES  = 2 * ITEM_CYCLES;
  localparam int RANDOM_ITEMS = 2000;
  // The key pool is larger than the ring so that old keys get evicted and
  // come back as new entries later on.
  localparam int POOL         = 96;

  logic clk;
  logic rst_n;

  dmf_in_if  in_ch ();
  dmf_out_if out_ch ();

  int fail_count;
  int pending_results;
  int hit_count;
  int store_count;
  int lookup_count;
  int idle_cycles;

  // Each side switches now and then into a stretch where it never idles.
  bit send_burst;
  bit recv_burst;

  logic [ID_W-1:0]    pool_id    [POOL];
  logic [NONCE_W-1:0] pool_nonce [POOL];

  duplicate_message_filter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dmf_filter_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .hit_count       (hit_count),
    .store_count     (store_count),
    .lookup_count    (lookup_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Presents one request after a random gap and holds it until it is taken.
  // The gap is drawn per item; valid stays high between back-to-back items.
  task automatic send_request(input logic act, input logic [ID_W-1:0] id,
                              input logic [NONCE_W-1:0] nonce,
                              input logic [TYPE_W-1:0] kind,
                              input logic [LEN_W-1:0] len);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.msg_id     <= id;
    in_ch.nonce      <= nonce;
    in_ch.msg_type   <= kind;
    in_ch.msg_length <= len;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Holds the sender back until every outstanding result has come out.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Result side: a fresh stall is drawn for every item it takes.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    recv_burst   = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 9);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // The watchdog ends the run when neither channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_results);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic               act;
    logic [ID_W-1:0]    id;
    logic [NONCE_W-1:0] nonce;
    logic [LEN_W-1:0]   len;
    int                 span;
    int                 idx;

    rst_n            = 1'b0;
    send_burst       = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_INSERT;
    in_ch.msg_id     = '0;
    in_ch.nonce      = '0;
    in_ch.msg_type   = '0;
    in_ch.msg_length = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A lookup in the empty ring must miss.
    send_request(ACT_LOOKUP, '0, '0, 8'hff, 8'd242);
    // Keys at the extremes of both fields, with extreme type and length values.
    // The last two carry lengths above 242, which must come back unchanged.
    send_request(ACT_INSERT, '0, '0, 8'h00, 8'd0);
    send_request(ACT_INSERT, '1, '1, 8'hff, 8'd242);
    send_request(ACT_INSERT, '1, '0, 8'ha5, 8'd255);
    send_request(ACT_INSERT, '0, '1, 8'h5a, 8'd243);
    // Each of those keys is found again with its stored type and length.
    send_request(ACT_LOOKUP, '0, '0, 8'h11, 8'd1);
    send_request(ACT_LOOKUP, '1, '1, 8'h22, 8'd2);
    send_request(ACT_LOOKUP, '1, '0, 8'h33, 8'd3);
    send_request(ACT_LOOKUP, '0, '1, 8'h44, 8'd4);
    // A duplicate insert returns the old entry and stores nothing.
    send_request(ACT_INSERT, '1, '1, 8'h00, 8'd0);
    send_request(ACT_INSERT, '0, '0, 8'hff, 8'd255);
    // Only one half of the key matches: these must miss.
    send_request(ACT_LOOKUP, 64'd1, '0, 8'h00, 8'd0);
    send_request(ACT_LOOKUP, '0, 32'd1, 8'h00, 8'd0);
    send_request(ACT_LOOKUP, {1'b0, {(ID_W-1){1'b1}}}, '1, 8'h00, 8'd0);
    send_request(ACT_LOOKUP, '1, {1'b0, {(NONCE_W-1){1'b1}}}, 8'h00, 8'd0);
    // Let the pipeline run empty once before the random part.
    drain_results();

    // Build a key pool in which some keys share an id or a nonce with another
    // one, so that partial matches are common.
    for (int i = 0; i < POOL; i++) begin
      pool_id[i]    = {$urandom, $urandom};
      pool_nonce[i] = $urandom;
      if (i > 0) begin
        case ($urandom_range(0, 3))
          0: pool_id[i] = pool_id[$urandom_range(0, i - 1)];
          1: pool_nonce[i] = pool_nonce[$urandom_range(0, i - 1)];
          default: ;
        endcase
      end
    end

    span = POOL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Switch between a small working set, where most requests hit, and the
      // whole pool, where the ring wraps and evicts keys that come back later.
      if (n % 200 == 0) span = ($urandom_range(0, 1) == 0) ? 24 : POOL;
      if (n > 0 && n % 450 == 0) drain_results();
      act = ($urandom_range(0, 99) < 55) ? ACT_INSERT : ACT_LOOKUP;
      if ($urandom_range(0, 99) < 85) begin
        idx   = $urandom_range(0, span - 1);
        id    = pool_id[idx];
        nonce = pool_nonce[idx];
      end else begin
        id    = {$urandom, $urandom};
        nonce = $urandom;
      end
      len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(243, 255))
                                        : LEN_W'($urandom_range(0, 242));
      send_request(act, id, nonce, TYPE_W'($urandom_range(0, 255)), len);
    end

    // Wait for every result, then give the block time to show stray output.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d lookups, %0d hits and %0d new entries stored",
             lookup_count, hit_count, store_count);
    $display("the %0d-entry ring wrapped %0d times", SLOTS, store_count / SLOTS);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
